@@ design/sau_pkg.sv @@
// package for the stack arithmetic unit: transaction types and codes
`default_nettype none
package sau_pkg;
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_SUB  = 3'd1,
    OP_DIV  = 3'd2,
    OP_MUL  = 3'd3,
    OP_REM  = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic [2:0]        operation;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         entry_count;
    logic               failed;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_DIV,
    S_MUL,
    S_WRITE,
    S_OUT
  } exec_state_t;
endpackage
`default_nettype wire

@@ design/stack_arith_unit.sv @@
// stack arithmetic unit top level: front queue and execution engine
//
// usage: transactions enter on in_valid/in_stall with in_data holding the
// operation and push value; each gives exactly one result on out_valid/
// out_stall carrying status, new top, entry count and sticky failed flag.
// a small front queue takes up to two transactions while the engine works.
// flow from acceptance to out_valid: push, unknown codes, too short and
// full stack go from read straight to write and output; subtract and zero
// divisor pass the wait state; multiply adds the product state; divide and
// remainder wait on the one-bit-per-cycle divider; one transaction at a time.
// the stack lives in a single memory read at two addresses with
// registered data; its contents need no clearing.
// reset clears the queue, stack count, failure flag and output valid flag.
// while out_stall is high the result is held and the engine waits with
// its next result; the queue keeps accepting until it holds two entries.
`default_nettype none
module stack_arith_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sau_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sau_pkg::out_item_t      out_data
);
  import sau_pkg::*;

  logic     q_valid;
  logic     q_take;
  in_item_t q_data;

  sau_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(q_valid), .out_take(q_take), .out_data(q_data)
  );

  sau_engine #(.STACK_DEPTH(STACK_DEPTH)) u_engine (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_data),
    .res_valid(out_valid), .res_stall(out_stall), .res(out_data)
  );

  a_take_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("engine took from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall) |-> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_in_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("queue stalls while empty");
endmodule
`default_nettype wire

@@ design/sau_queue.sv @@
// two-entry queue between the unit's input port and the execution engine
`default_nettype none
module sau_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sau_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_take,
  output sau_pkg::in_item_t      out_data
);
  import sau_pkg::*;

  in_item_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !(fill == 2'd0))
    else $error("queue fill inconsistent");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("queue overfilled");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> fill == $past(fill) - 2'd1)
    else $error("queue pop lost");
endmodule
`default_nettype wire

@@ design/sau_divider.sv @@
// iterative unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module sau_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);
  import sau_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  steps;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted   = {rem, quo[31]};
  assign trial     = shifted - {1'b0, dvs};
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 6'd0;
      end else if (busy) begin
        steps <= steps + 6'd1;
        if (steps == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without work");
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> steps <= 6'd31)
    else $error("divider ran too long");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider failed to start");
endmodule
`default_nettype wire

@@ design/sau_engine.sv @@
// execution engine: stack memory, arithmetic and result register
`default_nettype none
module sau_engine #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_take,
  input  wire sau_pkg::in_item_t  cmd,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output sau_pkg::out_item_t      res
);
  import sau_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0] mem [STACK_DEPTH];
  logic [CW-1:0] count, count_next;
  logic          failed, failed_next;
  exec_state_t   state, state_next;
  in_item_t      cur, cur_next;
  logic [31:0]   rd_s, rd_t;
  logic [AW-1:0] rd_addr_s, rd_addr_t;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   result, result_next;
  logic [1:0]    status, status_next;
  logic          div_start, div_done;
  logic [31:0]   div_q, div_r;
  logic [31:0]   mag_s, mag_t;
  logic [63:0]   prod;
  logic          out_valid, out_valid_next;
  out_item_t     out_reg, out_next;
  logic          bin_op;

  assign mag_s = rd_s[31] ? (32'd0 - rd_s) : rd_s;
  assign mag_t = rd_t[31] ? (32'd0 - rd_t) : rd_t;
  assign bin_op = (cur.operation == OP_SUB || cur.operation == OP_DIV ||
                   cur.operation == OP_MUL || cur.operation == OP_REM);

  always_ff @(posedge clk) begin
    rd_s <= mem[rd_addr_s];
    rd_t <= mem[rd_addr_t];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    prod <= 64'(rd_s) * 64'(rd_t);
  end

  sau_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(mag_s), .divisor(mag_t),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      failed    <= failed_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    result   <= result_next;
    status   <= status_next;
    out_reg  <= out_next;
  end

  assign res_valid = out_valid;
  assign res       = out_reg;

  always_comb begin
    state_next     = state;
    count_next     = count;
    failed_next    = failed;
    cur_next       = cur;
    result_next    = result;
    status_next    = status;
    out_next       = out_reg;
    out_valid_next = out_valid && res_stall;
    cmd_take       = 1'b0;
    div_start      = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = AW'(count);
    wr_data        = cur.push_value;
    rd_addr_t      = AW'(count - CW'(1));
    rd_addr_s      = AW'(count - CW'(2));
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take    = 1'b1;
          cur_next    = cmd;
          status_next = ST_OK;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        // memory read of top entries is in flight for this cycle
        case (cur.operation)
          OP_PUSH: begin
            if (count >= CW'(STACK_DEPTH)) begin
              status_next = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
            end
            state_next = S_WRITE;
          end
          OP_SUB, OP_DIV, OP_MUL, OP_REM: begin
            if (count < CW'(2)) begin
              status_next = ST_SHORT;
              state_next  = S_WRITE;
            end else begin
              state_next = S_WAIT;
            end
          end
          default: state_next = S_WRITE;
        endcase
      end
      S_WAIT: begin
        case (cur.operation)
          OP_SUB: begin
            result_next = rd_s - rd_t;
            state_next  = S_WRITE;
          end
          OP_MUL: state_next = S_MUL;
          default: begin
            if (rd_t == 32'd0) begin
              status_next = ST_DIVZERO;
              state_next  = S_WRITE;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        result_next = prod[31:0];
        state_next  = S_WRITE;
      end
      S_DIV: begin
        if (div_done) begin
          if (cur.operation == OP_DIV)
            result_next = (rd_s[31] ^ rd_t[31]) ? (32'd0 - div_q) : div_q;
          else
            result_next = rd_s[31] ? (32'd0 - div_r) : div_r;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        // binary result lands on the second entry and the stack shrinks
        if (cur.operation != OP_PUSH && status == ST_OK && count >= CW'(2) &&
            (cur.operation == OP_SUB || cur.operation == OP_DIV ||
             cur.operation == OP_MUL || cur.operation == OP_REM)) begin
          wr_en         = 1'b1;
          wr_addr       = AW'(count - CW'(2));
          wr_data       = result;
          count_next    = count - CW'(1);
        end
        rd_addr_t  = AW'(count_next - CW'(1));
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || !res_stall) begin
          out_next.status      = status;
          // the new top was written alongside its read, so take it directly
          if (bin_op && status == ST_OK)
            out_next.top_value = $signed(result);
          else
            out_next.top_value = (count == '0) ? 32'sd0 : $signed(rd_t);
          out_next.entry_count = 7'(count);
          out_next.failed      = failed || (status != ST_OK);
          failed_next          = failed || (status != ST_OK);
          out_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end else begin
          rd_addr_t = AW'(count - CW'(1));
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count out of range");
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(failed) && !$past(rst) |-> failed)
    else $error("failure flag cleared");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> (state == S_WRITE || state == S_OUT))
    else $error("count moved outside write");
endmodule
`default_nettype wire

@@ sim/tb_stack_arith_unit.sv @@
// testbench for the stack arithmetic unit: directed and random stack programs
`default_nettype none
module tb_stack_arith_unit;
  import sau_pkg::*;

  localparam int DEPTH      = 64;
  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  logic [31:0] model_stack [DEPTH];
  int          model_count = 0;
  logic        model_failed = 1'b0;
  out_item_t   pending_results [$];

  int  error_count = 0;
  int  quiet_cycles = 0;
  bit  calm_window = 1'b0;

  stack_arith_unit #(.STACK_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] abs_word(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic out_item_t predict_step(in_item_t item);
    out_item_t   res;
    logic [31:0] t, s, r;
    res.status = ST_OK;
    r = '0;
    if (item.operation == OP_PUSH) begin
      if (model_count >= DEPTH) res.status = ST_FULL;
      else begin
        model_stack[model_count] = item.push_value;
        model_count++;
      end
    end else if (item.operation <= OP_REM) begin
      if (model_count < 2) res.status = ST_SHORT;
      else begin
        t = model_stack[model_count-1];
        s = model_stack[model_count-2];
        if ((item.operation == OP_DIV || item.operation == OP_REM) && t == 0)
          res.status = ST_DIVZERO;
        else begin
          case (item.operation)
            OP_SUB: r = s - t;
            OP_MUL: r = s * t;
            OP_DIV: begin
              r = abs_word(s) / abs_word(t);
              if (s[31] ^ t[31]) r = -r;
            end
            default: begin
              r = abs_word(s) % abs_word(t);
              if (s[31]) r = -r;
            end
          endcase
          model_stack[model_count-2] = r;
          model_count--;
        end
      end
    end
    if (res.status != ST_OK) model_failed = 1'b1;
    res.top_value   = model_count > 0 ? model_stack[model_count-1] : '0;
    res.entry_count = model_count[6:0];
    res.failed      = model_failed;
    return res;
  endfunction

  // sends one transaction and records its expected result
  task automatic send_item(logic [2:0] op, logic [31:0] value);
    in_item_t item;
    item.operation  = op;
    item.push_value = value;
    while (!calm_window && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_step(item));
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm_window && ($urandom_range(99) < 7);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d top=%0d", out_data.status,
               out_data.top_value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status want %0d got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.top_value !== want.top_value) begin
          $error("top_value want %0d got %0d", want.top_value, out_data.top_value);
          error_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count want %0d got %0d", want.entry_count,
                 out_data.entry_count);
          error_count++;
        end
        if (out_data.failed !== want.failed) begin
          $error("failed want %0d got %0d", want.failed, out_data.failed);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return $urandom_range(9) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_errors_on_empty();
    send_item(OP_SUB, '0);
    send_item(OP_DIV, '0);
    send_item(OP_PUSH, 32'd7);
    send_item(OP_MUL, '0);
    send_item(OP_REM, '0);
    send_item(OP_BAD_LO, 32'hffff_ffff);
  endtask

  task automatic test_arith_extremes();
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PUSH, 32'hffff_ffff);
    send_item(OP_DIV, '0);          // most negative by minus one wraps
    send_item(OP_PUSH, 32'hffff_ffff);
    send_item(OP_REM, '0);
    send_item(OP_PUSH, '0);
    send_item(OP_DIV, '0);          // zero divisor
    send_item(OP_REM, '0);
    send_item(OP_BAD_HI, '0);
    send_item(OP_PUSH, 32'h7fff_ffff);
    send_item(OP_MUL, '0);
    send_item(OP_PUSH, -32'sd7);
    send_item(OP_PUSH, 32'd2);
    send_item(OP_REM, '0);
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_SUB, '0);
  endtask

  task automatic test_full_stack();
    while (model_count < DEPTH) send_item(OP_PUSH, rand_word());
    send_item(OP_PUSH, 32'd1);
    while (model_count > 1) send_item(OP_SUB, '0);
  endtask

  task automatic test_random_programs(int n);
    int op_pick;
    for (int i = 0; i < n; i++) begin
      calm_window = (i >= n/3 && i < n/2);
      op_pick = $urandom_range(99);
      // push-heavy while short so binary ops mostly find operands
      if (op_pick < (model_count < 3 ? 60 : 35)) send_item(OP_PUSH, rand_word());
      else if (op_pick < 97) send_item(3'($urandom_range(OP_REM, OP_SUB)), $urandom);
      else send_item(3'($urandom_range(OP_BAD_HI, OP_BAD_LO)), $urandom);
    end
    calm_window = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_errors_on_empty();
    test_arith_extremes();
    test_full_stack();
    test_random_programs(400);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
